[hdl/csit_pkg.sv]
// ============================================================================
// csit_pkg
// Shared types and constants for the circle versus 2D shape intersection test.
// ============================================================================
`default_nettype none

package csit_pkg;

    // Field widths of one request.
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int OP_W     = 2;

    // Number of register stages from request acceptance to the hit register.
    localparam int STAGES = 6;

    // Shape codes carried in the operation field.
    localparam logic [OP_W-1:0] OP_CIRCLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_BOX     = 2'd1;
    localparam logic [OP_W-1:0] OP_SEGMENT = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [RADIUS_W-1:0] radius_t;
    typedef logic        [OP_W-1:0]     op_t;

endpackage

`default_nettype wire

[hdl/csit_datapath.sv]
// ============================================================================
// csit_datapath
// Six-stage arithmetic pipeline: differences, products, sums, compares and
// split wide products, partial-product sums, final hit select.
// ============================================================================
`default_nettype none

module csit_datapath (
    input  wire logic                          clk,
    input  wire logic [csit_pkg::STAGES-1:0]   en,
    input  wire csit_pkg::op_t                 operation,
    input  wire logic                          other_is_3d,
    input  wire csit_pkg::coord_t              center_x,
    input  wire csit_pkg::coord_t              center_y,
    input  wire csit_pkg::radius_t             radius,
    input  wire csit_pkg::radius_t             other_radius,
    input  wire csit_pkg::coord_t              first_x,
    input  wire csit_pkg::coord_t              first_y,
    input  wire csit_pkg::coord_t              second_x,
    input  wire csit_pkg::coord_t              second_y,
    output logic                               hit
);
    import csit_pkg::*;

    // ---------------- Stage 1: coordinate differences ----------------
    logic signed [16:0] dx, dy, bdx, bdy, ex_next, ey_next, vx_next, vy_next;
    logic signed [16:0] p1x_next, p1y_next;
    coord_t             px, py;
    logic        [15:0] t_next;
    logic               live_next;

    logic signed [16:0] s1_p1x_reg, s1_p1y_reg, s1_ex_reg, s1_ey_reg;
    logic signed [16:0] s1_vx_reg, s1_vy_reg, s1_wx_reg, s1_wy_reg;
    logic        [15:0] s1_t_reg;
    op_t                s1_op_reg;
    logic               s1_live_reg;

    always_comb
    begin
        dx = 17'(center_x) - 17'(first_x);
        dy = 17'(center_y) - 17'(first_y);

        // Closest box point: minimum first, then maximum, else the center.
        if (center_x < first_x)
            px = first_x;
        else if (second_x < center_x)
            px = second_x;
        else
            px = center_x;
        if (center_y < first_y)
            py = first_y;
        else if (second_y < center_y)
            py = second_y;
        else
            py = center_y;
        bdx = 17'(center_x) - 17'(px);
        bdy = 17'(center_y) - 17'(py);

        // The near distance uses the box point or the first point.
        p1x_next = (operation == OP_BOX) ? bdx : dx;
        p1y_next = (operation == OP_BOX) ? bdy : dy;

        ex_next = 17'(center_x) - 17'(second_x);
        ey_next = 17'(center_y) - 17'(second_y);
        vx_next = 17'(second_x) - 17'(first_x);
        vy_next = 17'(second_y) - 17'(first_y);

        // Circle pairs compare against the summed radii.
        if (operation == OP_CIRCLE)
            t_next = {1'b0, radius} + {1'b0, other_radius};
        else
            t_next = {1'b0, radius};

        live_next = !other_is_3d && (operation != OP_NONE);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_p1x_reg  <= p1x_next;
            s1_p1y_reg  <= p1y_next;
            s1_ex_reg   <= ex_next;
            s1_ey_reg   <= ey_next;
            s1_vx_reg   <= vx_next;
            s1_vy_reg   <= vy_next;
            s1_wx_reg   <= dx;
            s1_wy_reg   <= dy;
            s1_t_reg    <= t_next;
            s1_op_reg   <= operation;
            s1_live_reg <= live_next;
        end
    end

    // ---------------- Stage 2: products ----------------
    logic signed [33:0] sq_p1x, sq_p1y, sq_ex, sq_ey;
    logic signed [33:0] vxwx, vywy, vxvx, vyvy, vxwy, vywx;

    logic        [31:0] s2_p1x2_reg, s2_p1y2_reg, s2_ex2_reg, s2_ey2_reg;
    logic        [31:0] s2_vxvx_reg, s2_vyvy_reg, s2_t2_reg;
    logic signed [33:0] s2_vxwx_reg, s2_vywy_reg, s2_vxwy_reg, s2_vywx_reg;
    op_t                s2_op_reg;
    logic               s2_live_reg;

    always_comb
    begin
        sq_p1x = s1_p1x_reg * s1_p1x_reg;
        sq_p1y = s1_p1y_reg * s1_p1y_reg;
        sq_ex  = s1_ex_reg * s1_ex_reg;
        sq_ey  = s1_ey_reg * s1_ey_reg;
        vxwx   = s1_vx_reg * s1_wx_reg;
        vywy   = s1_vy_reg * s1_wy_reg;
        vxvx   = s1_vx_reg * s1_vx_reg;
        vyvy   = s1_vy_reg * s1_vy_reg;
        vxwy   = s1_vx_reg * s1_wy_reg;
        vywx   = s1_vy_reg * s1_wx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            // Squares of 17-bit differences stay below 2^32.
            s2_p1x2_reg <= sq_p1x[31:0];
            s2_p1y2_reg <= sq_p1y[31:0];
            s2_ex2_reg  <= sq_ex[31:0];
            s2_ey2_reg  <= sq_ey[31:0];
            s2_vxvx_reg <= vxvx[31:0];
            s2_vyvy_reg <= vyvy[31:0];
            s2_t2_reg   <= s1_t_reg * s1_t_reg;
            s2_vxwx_reg <= vxwx;
            s2_vywy_reg <= vywy;
            s2_vxwy_reg <= vxwy;
            s2_vywx_reg <= vywx;
            s2_op_reg   <= s1_op_reg;
            s2_live_reg <= s1_live_reg;
        end
    end

    // ---------------- Stage 3: sums, dot and cross products ----------------
    logic signed [34:0] dot_next, cross_next, cross_neg;
    logic        [32:0] acr_next;

    logic        [32:0] s3_dist1_reg, s3_dist2_reg, s3_q_reg, s3_acr_reg;
    logic signed [34:0] s3_d_reg;
    logic        [31:0] s3_t2_reg;
    op_t                s3_op_reg;
    logic               s3_live_reg;

    always_comb
    begin
        dot_next   = 35'(s2_vxwx_reg) + 35'(s2_vywy_reg);
        cross_next = 35'(s2_vxwy_reg) - 35'(s2_vywx_reg);
        cross_neg  = -cross_next;
        // The cross product magnitude stays below 2^33.
        acr_next   = cross_next[34] ? cross_neg[32:0] : cross_next[32:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_dist1_reg <= {1'b0, s2_p1x2_reg} + {1'b0, s2_p1y2_reg};
            s3_dist2_reg <= {1'b0, s2_ex2_reg} + {1'b0, s2_ey2_reg};
            s3_q_reg     <= {1'b0, s2_vxvx_reg} + {1'b0, s2_vyvy_reg};
            s3_d_reg     <= dot_next;
            s3_acr_reg   <= acr_next;
            s3_t2_reg    <= s2_t2_reg;
            s3_op_reg    <= s2_op_reg;
            s3_live_reg  <= s2_live_reg;
        end
    end

    // ---------------- Stage 4: end-point compares and split products ----------------
    logic        start_sel, end_sel, lt1, le1, le2, pre_next, mid_next;
    logic [16:0] ah, qh;
    logic [15:0] al, ql;
    logic [29:0] r2;

    logic [33:0] s4_ahah_reg;
    logic [32:0] s4_ahal_reg;
    logic [31:0] s4_alal_reg;
    logic [46:0] s4_r2qh_reg;
    logic [45:0] s4_r2ql_reg;
    logic        s4_pre_reg, s4_mid_reg, s4_live_reg;

    always_comb
    begin
        lt1 = s3_dist1_reg <  {1'b0, s3_t2_reg};
        le1 = s3_dist1_reg <= {1'b0, s3_t2_reg};
        le2 = s3_dist2_reg <= {1'b0, s3_t2_reg};

        // Degenerate segment or projection at or before the start point.
        start_sel = (s3_q_reg == '0) || (s3_d_reg <= 35'sd0);
        end_sel   = s3_d_reg >= $signed({2'b00, s3_q_reg});

        pre_next = 1'b0;
        mid_next = 1'b0;
        case (s3_op_reg) inside
            OP_CIRCLE, OP_BOX:
            begin
                pre_next = lt1;
            end
            OP_SEGMENT:
            begin
                if (start_sel)
                    pre_next = le1;
                else if (end_sel)
                    pre_next = le2;
                else
                    mid_next = 1'b1;
            end
            default:
            begin
                pre_next = 1'b0;
            end
        endcase

        ah = s3_acr_reg[32:16];
        al = s3_acr_reg[15:0];
        qh = s3_q_reg[32:16];
        ql = s3_q_reg[15:0];
        r2 = s3_t2_reg[29:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_ahah_reg <= ah * ah;
            s4_ahal_reg <= ah * al;
            s4_alal_reg <= al * al;
            s4_r2qh_reg <= r2 * qh;
            s4_r2ql_reg <= r2 * ql;
            s4_pre_reg  <= pre_next;
            s4_mid_reg  <= mid_next;
            s4_live_reg <= s3_live_reg;
        end
    end

    // ---------------- Stage 5: sum of partial products ----------------
    logic [65:0] s5_lhs_reg;
    logic [62:0] s5_rhs_reg;
    logic        s5_pre_reg, s5_mid_reg, s5_live_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            // cross^2 and radius^2 * |v|^2 rebuilt from their halves.
            s5_lhs_reg  <= ({32'd0, s4_ahah_reg} << 32)
                         + ({33'd0, s4_ahal_reg} << 17)
                         + {34'd0, s4_alal_reg};
            s5_rhs_reg  <= ({16'd0, s4_r2qh_reg} << 16) + {17'd0, s4_r2ql_reg};
            s5_pre_reg  <= s4_pre_reg;
            s5_mid_reg  <= s4_mid_reg;
            s5_live_reg <= s4_live_reg;
        end
    end

    // ---------------- Stage 6: hit register ----------------
    logic hit_next;
    logic hit_reg;

    always_comb
    begin
        if (s5_mid_reg)
            hit_next = s5_live_reg && (s5_lhs_reg <= {3'b000, s5_rhs_reg});
        else
            hit_next = s5_live_reg && s5_pre_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

[hdl/circle_shape_intersection_test.sv]
// Throughput: one request per cycle while out_ready is high; each of the six
// stages holds its own valid bit, and a stage advances whenever the stage after
// it is empty or moving. Most stages hold multiplier work: products, their sums,
// a second split multiply for the segment cross test, and its partial-product sum.
// Reset clears only the stage valid bits; the data registers are not reset.
// ============================================================================
// circle_shape_intersection_test
// Tests a circle against a circle, an axis-aligned box or a segment and
// returns a hit flag per request through a valid/ready pipeline.
// ============================================================================
`default_nettype none

module circle_shape_intersection_test (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire csit_pkg::op_t      operation,
    input  wire logic               other_is_3d,
    input  wire csit_pkg::coord_t   center_x,
    input  wire csit_pkg::coord_t   center_y,
    input  wire csit_pkg::radius_t  radius,
    input  wire csit_pkg::radius_t  other_radius,
    input  wire csit_pkg::coord_t   first_x,
    input  wire csit_pkg::coord_t   first_y,
    input  wire csit_pkg::coord_t   second_x,
    input  wire csit_pkg::coord_t   second_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    hit
);
    import csit_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   en;

    // Stage enables: a stage may load when it is empty or its content moves on.
    always_comb
    begin
        en[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (!en[k])
                valid_next[k] = valid_reg[k];
            else if (k == 0)
                valid_next[k] = in_valid;
            else
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];

    // Arithmetic pipeline.
    csit_datapath u_datapath (
        .clk          (clk),
        .en           (en[STAGES-1:0]),
        .operation    (operation),
        .other_is_3d  (other_is_3d),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .other_radius (other_radius),
        .first_x      (first_x),
        .first_y      (first_y),
        .second_x     (second_x),
        .second_y     (second_y),
        .hit          (hit)
    );

    // An empty pipeline always takes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == '0) |-> in_ready)
        else $error("empty pipeline refused a request");

    // A drained output lets the whole pipeline move.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline stalled while the output was ready");

    // Requests in flight grow by one when a request enters and none leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !(out_valid && out_ready))
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("request lost or duplicated on entry");

    // Requests in flight drop by one when a result leaves and none enters.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && in_ready) && out_valid && out_ready)
        |=> ($countones(valid_reg) + 1 == $past($countones(valid_reg))))
        else $error("request lost or duplicated on exit");

endmodule

`default_nettype wire

[dv/circle_shape_intersection_test_tb.sv]
// ============================================================================
// circle_shape_intersection_test_tb
// Drives circle versus circle, box, segment and no-hit requests into the
// pipeline and compares every hit flag with a behavioral predictor, under random
// idling on both channels, a long output stall and a final stretch at full rate.
// ============================================================================

module circle_shape_intersection_test_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import csit_pkg::*;

    // One request as seen on the input ports.
    typedef struct {
        op_t     operation;
        logic    other_is_3d;
        coord_t  center_x;
        coord_t  center_y;
        radius_t radius;
        radius_t other_radius;
        coord_t  first_x;
        coord_t  first_y;
        coord_t  second_x;
        coord_t  second_y;
    } shape_req_t;

    // Wide enough for a squared cross product against radius^2 times length^2.
    typedef logic signed [95:0] wide_t;

    localparam int CYCLE_LIMIT = 400000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    op_t     operation = OP_CIRCLE;
    logic    other_is_3d = 1'b0;
    coord_t  center_x = '0;
    coord_t  center_y = '0;
    radius_t radius = '0;
    radius_t other_radius = '0;
    coord_t  first_x = '0;
    coord_t  first_y = '0;
    coord_t  second_x = '0;
    coord_t  second_y = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    logic    hit;

    bit expected_hits[$];
    int error_count = 0;
    int cycle_count = 0;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_hold_left = 0;

    circle_shape_intersection_test u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .other_is_3d  (other_is_3d),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .other_radius (other_radius),
        .first_x      (first_x),
        .first_y      (first_y),
        .second_x     (second_x),
        .second_y     (second_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit)
    );

    // Free-running clock with a 10 ns period.
    always #5 clk = ~clk;

    // Squared distance between two points.
    function automatic wide_t dist_sq(input wide_t ax, input wide_t ay,
                                      input wide_t bx, input wide_t by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    // Closest coordinate on one box axis; the minimum is checked first, so an
    // inverted box resolves the same way as in the block.
    function automatic wide_t clamp_axis(input wide_t c, input wide_t lo,
                                         input wide_t hi_bound);
        if (c < lo)
            return lo;
        if (hi_bound < c)
            return hi_bound;
        return c;
    endfunction

    // Expected hit flag of one request, in exact wide integer arithmetic.
    function automatic bit predict_hit(input shape_req_t rq);
        wide_t cx, cy, r, ro, ax, ay, bx, by;
        wide_t vx, vy, wx, wy, d, q, cr, rs;
        bit    result;
        cx = rq.center_x;
        cy = rq.center_y;
        r  = rq.radius;
        ro = rq.other_radius;
        ax = rq.first_x;
        ay = rq.first_y;
        bx = rq.second_x;
        by = rq.second_y;
        result = 1'b0;
        if (!rq.other_is_3d)
        begin
            case (rq.operation)
                OP_CIRCLE:
                begin
                    rs = r + ro;
                    result = dist_sq(cx, cy, ax, ay) < rs * rs;
                end
                OP_BOX:
                begin
                    result = dist_sq(cx, cy, clamp_axis(cx, ax, bx),
                                     clamp_axis(cy, ay, by)) < r * r;
                end
                OP_SEGMENT:
                begin
                    vx = bx - ax;
                    vy = by - ay;
                    wx = cx - ax;
                    wy = cy - ay;
                    d  = vx * wx + vy * wy;
                    q  = vx * vx + vy * vy;
                    if (q == 0 || d <= 0)
                        result = dist_sq(cx, cy, ax, ay) <= r * r;
                    else if (d >= q)
                        result = dist_sq(cx, cy, bx, by) <= r * r;
                    else
                    begin
                        cr = vx * wy - vy * wx;
                        result = cr * cr <= r * r * q;
                    end
                end
                default:
                begin
                    result = 1'b0;
                end
            endcase
        end
        return result;
    endfunction

    function automatic shape_req_t make_request(input op_t op, input bit is_3d,
                                                input int cx, input int cy,
                                                input int r, input int ro,
                                                input int ax, input int ay,
                                                input int bx, input int by);
        shape_req_t rq;
        rq.operation    = op;
        rq.other_is_3d  = is_3d;
        rq.center_x     = coord_t'(cx);
        rq.center_y     = coord_t'(cy);
        rq.radius       = radius_t'(r);
        rq.other_radius = radius_t'(ro);
        rq.first_x      = coord_t'(ax);
        rq.first_y      = coord_t'(ay);
        rq.second_x     = coord_t'(bx);
        rq.second_y     = coord_t'(by);
        return rq;
    endfunction

    // Random request: mostly shapes clustered around one point at a random
    // scale so that hits and misses both occur, sometimes fully random fields.
    function automatic shape_req_t random_request();
        shape_req_t rq;
        int         base_x, base_y, span;
        rq.operation   = op_t'($urandom_range(0, 3));
        rq.other_is_3d = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 3) == 0)
        begin
            rq.center_x     = coord_t'($urandom);
            rq.center_y     = coord_t'($urandom);
            rq.radius       = radius_t'($urandom);
            rq.other_radius = radius_t'($urandom);
            rq.first_x      = coord_t'($urandom);
            rq.first_y      = coord_t'($urandom);
            rq.second_x     = coord_t'($urandom);
            rq.second_y     = coord_t'($urandom);
        end
        else
        begin
            span   = 1 << $urandom_range(2, 14);
            base_x = int'($urandom_range(0, 65535)) - 32768;
            base_y = int'($urandom_range(0, 65535)) - 32768;
            rq.center_x     = coord_t'(base_x + int'($urandom_range(0, 2 * span)) - span);
            rq.center_y     = coord_t'(base_y + int'($urandom_range(0, 2 * span)) - span);
            rq.radius       = radius_t'($urandom_range(0, span));
            rq.other_radius = radius_t'($urandom_range(0, span));
            rq.first_x      = coord_t'(base_x + int'($urandom_range(0, 2 * span)) - span);
            rq.first_y      = coord_t'(base_y + int'($urandom_range(0, 2 * span)) - span);
            rq.second_x     = coord_t'(base_x + int'($urandom_range(0, 2 * span)) - span);
            rq.second_y     = coord_t'(base_y + int'($urandom_range(0, 2 * span)) - span);
        end
        return rq;
    endfunction

    // Offer one request and wait for it to be taken. Called at a rising edge;
    // leaves valid high so the next request can follow without a bubble.
    task automatic send_request(input shape_req_t rq);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= rq.operation;
        other_is_3d  <= rq.other_is_3d;
        center_x     <= rq.center_x;
        center_y     <= rq.center_y;
        radius       <= rq.radius;
        other_radius <= rq.other_radius;
        first_x      <= rq.first_x;
        first_y      <= rq.first_y;
        second_x     <= rq.second_x;
        second_y     <= rq.second_y;
        do
            @(posedge clk);
        while (!in_ready);
        expected_hits.push_back(predict_hit(rq));
    endtask

    // Circle pairs: overlap, exact touch, zero radii and the coordinate extremes.
    task automatic test_circle_cases();
        send_request(make_request(OP_CIRCLE, 0, 0, 0, 256, 256, 256, 0, 0, 0));
        send_request(make_request(OP_CIRCLE, 0, 0, 0, 256, 256, 512, 0, 0, 0));
        send_request(make_request(OP_CIRCLE, 0, 100, -100, 0, 0, 100, -100, 5, 5));
        send_request(make_request(OP_CIRCLE, 0, -32768, -32768, 32767, 32767,
                                  32767, 32767, -1, -1));
        send_request(make_request(OP_CIRCLE, 0, 32767, -32768, 32767, 32767,
                                  32767, -32768, 32767, -32768));
    endtask

    // Boxes: inside, touching an edge, near a corner, inverted, zero radius.
    task automatic test_box_cases();
        send_request(make_request(OP_BOX, 0, 0, 0, 16, 0, -512, -512, 512, 512));
        send_request(make_request(OP_BOX, 0, 0, 0, 256, 0, 256, -256, 512, 256));
        send_request(make_request(OP_BOX, 0, 0, 0, 363, 0, 256, 256, 512, 512));
        send_request(make_request(OP_BOX, 0, 0, 0, 1, 0, 512, 512, -512, -512));
        send_request(make_request(OP_BOX, 0, 600, 0, 32767, 0, 512, 512, -512, -512));
        send_request(make_request(OP_BOX, 0, 0, 0, 0, 0, -32768, -32768, 32767, 32767));
    endtask

    // Segments: a point-like segment, both end regions, the middle at exactly
    // the radius and just past it, the extremes and a zero radius on the line.
    task automatic test_segment_cases();
        send_request(make_request(OP_SEGMENT, 0, 256, 0, 256, 0, 256, 256, 256, 256));
        send_request(make_request(OP_SEGMENT, 0, -256, 0, 256, 0, 0, 0, 1024, 0));
        send_request(make_request(OP_SEGMENT, 0, 1280, 0, 255, 0, 0, 0, 1024, 0));
        send_request(make_request(OP_SEGMENT, 0, 512, 256, 256, 0, 0, 0, 1024, 0));
        send_request(make_request(OP_SEGMENT, 0, 512, 257, 256, 0, 0, 0, 1024, 0));
        send_request(make_request(OP_SEGMENT, 0, 32767, -32768, 32767, 0,
                                  -32768, -32768, 32767, 32767));
        send_request(make_request(OP_SEGMENT, 0, 512, 512, 0, 0, 0, 0, 1024, 1024));
    endtask

    // Unsupported shape and 3D other shapes, all with geometry that would hit.
    task automatic test_no_hit_cases();
        send_request(make_request(OP_NONE, 0, 0, 0, 1024, 1024, 0, 0, 0, 0));
        send_request(make_request(OP_CIRCLE, 1, 0, 0, 256, 256, 256, 0, 0, 0));
        send_request(make_request(OP_BOX, 1, 0, 0, 16, 0, -512, -512, 512, 512));
        send_request(make_request(OP_SEGMENT, 1, 512, 0, 256, 0, 0, 0, 1024, 0));
        send_request(make_request(OP_NONE, 1, 0, 0, 1024, 1024, 0, 0, 0, 0));
    endtask

    // Random requests with idling on both channels.
    task automatic test_random_traffic(input int count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (count) send_request(random_request());
    endtask

    // Output held off for a long stretch while requests keep coming, so the
    // pipeline fills and backpressure reaches the input.
    task automatic test_output_stall();
        tx_idle_on   = 1'b0;
        rx_hold_left = 300;
        repeat (60) send_request(random_request());
    endtask

    // Final stretch at full rate with no idling on either side.
    task automatic test_full_rate(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (count) send_request(random_request());
    endtask

    // Output ready: long hold-off when requested, else stall bursts if idling is on.
    initial
    begin
        int burst_left;
        burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end
            else if (burst_left > 0)
            begin
                out_ready <= 1'b0;
                burst_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready  <= 1'b0;
                burst_left = $urandom_range(1, 12) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each accepted hit flag with the oldest expectation.
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t ERROR unexpected result: expected none actual hit=%0b",
                         $time, hit);
                error_count++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (hit !== want)
                begin
                    $display("%0t ERROR hit mismatch: expected %0b actual %0b",
                             $time, want, hit);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ERROR timeout after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_circle_cases();
        test_box_cases();
        test_segment_cases();
        test_no_hit_cases();
        test_random_traffic(1000);
        test_output_stall();
        test_full_rate(270);
        in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge clk);
        repeat (STAGES + 4) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
